// ----- sv/sdoc_pkg.sv -----
package sdoc_pkg;

  localparam logic [1:0] REQ_UPLOAD   = 2'd0;
  localparam logic [1:0] REQ_DOWNLOAD = 2'd1;
  localparam logic [1:0] REQ_FRAME    = 2'd2;
  localparam logic [1:0] REQ_TICK     = 2'd3;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_UPLOAD   = 2'd1;
  localparam logic [1:0] PH_DOWNLOAD = 2'd2;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ABORT      = 2'd1;
  localparam logic [1:0] ST_TIMEOUT    = 2'd2;
  localparam logic [1:0] ST_UNEXPECTED = 2'd3;

  localparam logic [2:0] CS_UP_SEG   = 3'd0;
  localparam logic [2:0] CS_DN_SEG   = 3'd1;
  localparam logic [2:0] CS_UP_INIT  = 3'd2;
  localparam logic [2:0] CS_DN_INIT  = 3'd3;
  localparam logic [2:0] CS_ABORT    = 3'd4;

  localparam logic [0:0] CFG_SERVER_NODE   = 1'd0;
  localparam logic [0:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [31:0] CODE_TIMEOUT = 32'h0504_0000;
  localparam logic [31:0] CODE_GENERAL = 32'h0800_0000;
  localparam logic [10:0] RX_BASE      = 11'h580;
  localparam logic [10:0] TX_BASE      = 11'h600;
  localparam logic [6:0]  NODE_RESET    = 7'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] object_index;
    logic [7:0]  object_subindex;
    logic [31:0] write_data;
    logic [2:0]  data_size_kind;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [10:0] tx_id;
    logic [63:0] tx_payload;
    logic [55:0] data_value;
    logic [2:0]  data_count;
    logic [1:0]  finish_status;
    logic [31:0] server_abort_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [15:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] active_index;
    logic [7:0]  active_subindex;
    logic [15:0] idle_tick_count;
  } sdoc_state_t;

endpackage

// ----- sv/sdoc_chan_if.sv -----
interface sdoc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- sv/sdoc_engine.sv -----
module sdoc_engine
  import sdoc_pkg::*;
(
  input  in_item_t    item,
  input  sdoc_state_t st,
  input  logic [6:0]  server_node,
  input  logic [15:0] timeout_ticks,
  output sdoc_state_t st_next,
  output out_item_t   res0,
  output out_item_t   res1,
  output logic [1:0]  res_count
);

  logic        busy;
  logic [10:0] tx_id;
  logic [10:0] rx_id;
  logic [7:0]  b0;
  logic [2:0]  cs;
  logic        obj_ok;
  logic [31:0] d32;
  logic [15:0] tick_inc;
  logic [2:0]  exp_cnt;
  logic [31:0] exp_val;
  logic [2:0]  seg_cnt;
  logic [55:0] seg_val;
  logic [31:0] dn_data;
  logic [7:0]  dn_b0;
  logic [63:0] abort_base;

  function automatic out_item_t frame_res(logic [10:0] id, logic [63:0] pl);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_FRAME;
    r.tx_id = id;
    r.tx_payload = pl;
    return r;
  endfunction

  function automatic out_item_t data_res(logic [55:0] v, logic [2:0] cnt);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_DATA;
    r.data_value = v;
    r.data_count = cnt;
    return r;
  endfunction

  function automatic out_item_t fin_res(logic [1:0] status, logic [31:0] code);
    out_item_t r;
    r = '0;
    r.out_kind = KIND_FINISH;
    r.finish_status = status;
    r.server_abort_code = code;
    return r;
  endfunction

  assign busy   = st.phase inside {PH_UPLOAD, PH_DOWNLOAD};
  assign tx_id  = TX_BASE + {4'd0, server_node};
  assign rx_id  = RX_BASE + {4'd0, server_node};
  assign b0     = item.frame_bytes[7:0];
  assign cs     = b0[7:5];
  assign d32    = item.frame_bytes[63:32];
  assign obj_ok = item.frame_bytes[31:8] == {st.active_subindex, st.active_index};
  assign tick_inc = (st.idle_tick_count != 16'hFFFF) ? st.idle_tick_count + 16'd1
                                                     : st.idle_tick_count;
  assign abort_base = {32'd0, st.active_subindex, st.active_index, 8'h80};

  // Byte counts and masks for expedited and segmented upload data.
  assign exp_cnt = b0[0] ? (3'd4 - {1'b0, b0[3:2]}) : 3'd4;
  assign seg_cnt = 3'd7 - b0[3:1];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      exp_val[8*i +: 8] = (3'(i) < exp_cnt) ? d32[8*i +: 8] : 8'd0;
    end
    for (int i = 0; i < 7; i++) begin
      seg_val[8*i +: 8] = (3'(i) < seg_cnt) ? item.frame_bytes[8 + 8*i +: 8] : 8'd0;
    end
  end

  always_comb begin
    dn_b0 = 8'h22;
    dn_data = item.write_data;
    case (item.data_size_kind)
      3'd0: begin
        dn_b0 = 8'h23;
      end
      3'd1: begin
        dn_b0 = 8'h27;
        dn_data = {8'd0, item.write_data[23:0]};
      end
      3'd2: begin
        dn_b0 = 8'h2B;
        dn_data = {16'd0, item.write_data[15:0]};
      end
      3'd3: begin
        dn_b0 = 8'h2F;
        dn_data = {24'd0, item.write_data[7:0]};
      end
      default: begin
        dn_b0 = 8'h22;
      end
    endcase
  end

  always_comb begin
    st_next = st;
    res0 = '0;
    res1 = '0;
    res_count = 2'd0;
    case (item.req_type)
      REQ_UPLOAD, REQ_DOWNLOAD: begin
        if (!busy) begin
          st_next.active_index = item.object_index;
          st_next.active_subindex = item.object_subindex;
          st_next.idle_tick_count = 16'd0;
          res_count = 2'd1;
          if (item.req_type == REQ_UPLOAD) begin
            st_next.phase = PH_UPLOAD;
            res0 = frame_res(tx_id, {32'd0, item.object_subindex,
                                     item.object_index, 8'h40});
          end else begin
            st_next.phase = PH_DOWNLOAD;
            res0 = frame_res(tx_id, {dn_data, item.object_subindex,
                                     item.object_index, dn_b0});
          end
        end
      end
      REQ_FRAME: begin
        if (busy && (item.frame_id == rx_id) && (item.frame_len == 4'd8)) begin
          if ((cs == CS_ABORT) && obj_ok) begin
            res0 = fin_res(ST_ABORT, d32);
            res_count = 2'd1;
            st_next.phase = PH_IDLE;
          end else if (st.phase == PH_UPLOAD) begin
            if ((cs == CS_UP_INIT) && obj_ok) begin
              if (!b0[1] && b0[0]) begin
                res0 = frame_res(tx_id, 64'h60);
                res_count = 2'd1;
                st_next.idle_tick_count = 16'd0;
              end else if (b0[1]) begin
                res0 = data_res({24'd0, exp_val}, exp_cnt);
                res1 = fin_res(ST_OK, 32'd0);
                res_count = 2'd2;
                st_next.phase = PH_IDLE;
              end else begin
                res0 = fin_res(ST_OK, 32'd0);
                res_count = 2'd1;
                st_next.phase = PH_IDLE;
              end
            end else if (cs == CS_UP_SEG) begin
              res0 = data_res(seg_val, seg_cnt);
              res_count = 2'd2;
              if (!b0[0]) begin
                res1 = frame_res(tx_id, {56'd0, 3'b011, ~b0[4], 4'd0});
                st_next.idle_tick_count = 16'd0;
              end else begin
                res1 = fin_res(ST_OK, 32'd0);
                st_next.phase = PH_IDLE;
              end
            end
          end else begin
            if ((cs == CS_DN_INIT) && obj_ok) begin
              res0 = fin_res(ST_OK, 32'd0);
              res_count = 2'd1;
              st_next.phase = PH_IDLE;
            end else if (cs == CS_DN_SEG) begin
              res0 = frame_res(tx_id, abort_base | {CODE_GENERAL, 32'd0});
              res1 = fin_res(ST_UNEXPECTED, 32'd0);
              res_count = 2'd2;
              st_next.idle_tick_count = 16'd0;
              st_next.phase = PH_IDLE;
            end
          end
        end
      end
      default: begin
        if (busy) begin
          st_next.idle_tick_count = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            res0 = frame_res(tx_id, abort_base | {CODE_TIMEOUT, 32'd0});
            res1 = fin_res(ST_TIMEOUT, 32'd0);
            res_count = 2'd2;
            st_next.idle_tick_count = 16'd0;
            st_next.phase = PH_IDLE;
          end
        end
      end
    endcase
    if (res_count == 2'd1) begin
      res0.last = 1'b1;
    end
    if (res_count == 2'd2) begin
      res1.last = 1'b1;
    end
  end

endmodule

// ----- sv/sdoc_res_queue.sv -----
module sdoc_res_queue
  import sdoc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  out_item_t  push0,
  input  out_item_t  push1,
  output logic       room,
  sdoc_chan_if.source rsp
);

  out_item_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              pop;

  assign pop       = rsp.valid && rsp.ready;
  assign rsp.valid = count != '0;
  assign rsp.data  = mem[rptr];
  // Room for the two results that one item can produce.
  assign room      = count <= (QPTR_W + 1)'(QUEUE_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wptr + QPTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push_count);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count + (QPTR_W + 1)'(push_count) - (QPTR_W + 1)'(pop);
    end
  end

endmodule

// ----- sv/sdo_client_transfer_engine_top.sv -----
// CANopen SDO client engine for expedited and segmented upload and expedited download.
// Each beat on req is a start command, a received CAN frame or a timer tick; each beat
// on rsp is a frame to transmit, a block of uploaded bytes or a transfer-finished
// status, and the last beat caused by a request has last set. An accepted request is held
// in the input register and is resolved from there by combinational logic, which is
// allowed whenever the four-entry result queue has room for two beats; a request that
// causes one result sustains one request per cycle while rsp drains the queue, and one
// that causes two is bounded by the rsp drain rate. The cfg channel is always ready and
// must only be written while no transfer results are outstanding.
module sdo_client_transfer_engine_top
  import sdoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sdoc_chan_if.sink   req,
  sdoc_chan_if.source rsp,
  sdoc_chan_if.sink   cfg
);

  in_item_t    in_q;
  logic        in_valid;
  logic        fire;
  logic        room;
  sdoc_state_t st;
  sdoc_state_t st_next;
  out_item_t   res0;
  out_item_t   res1;
  logic [1:0]  res_count;
  logic [6:0]  server_node;
  logic [15:0] timeout_ticks;

  assign fire      = in_valid && room;
  assign req.ready = !in_valid || fire;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_node   <= NODE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_SERVER_NODE: begin
          server_node <= cfg.data.wdata[6:0];
        end
        CFG_TIMEOUT_TICKS: begin
          timeout_ticks <= cfg.data.wdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, active_index: '0, active_subindex: '0,
              idle_tick_count: '0};
    end else if (fire) begin
      st <= st_next;
    end
  end

  sdoc_engine u_engine (
    .item          (in_q),
    .st            (st),
    .server_node   (server_node),
    .timeout_ticks (timeout_ticks),
    .st_next       (st_next),
    .res0          (res0),
    .res1          (res1),
    .res_count     (res_count)
  );

  sdoc_res_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (fire ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .room       (room),
    .rsp        (rsp)
  );

endmodule
